// File: rtl/vcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types and codes for the video controller cursor and scan-out block.
// ----------------------------------------------------------------------------
package vcc_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] colour_t;

  // bus register numbers
  typedef enum logic [3:0] {
    REG_CONF = 4'd0,
    REG_REPT = 4'd1,
    REG_PTRX = 4'd2,
    REG_PTRY = 4'd3,
    REG_WDAT = 4'd4,
    REG_DISP = 4'd5,
    REG_CHRW = 4'd6,
    REG_CHRH = 4'd7
  } reg_index_t;

  // commands carried in the upper nibble of a conf write
  typedef enum logic [3:0] {
    CONF_FRAME = 4'd0,
    CONF_MODE  = 4'd1,
    CONF_COL0  = 4'd2,
    CONF_COL1  = 4'd3
  } conf_cmd_t;

  localparam logic ACT_REG_WRITE   = 1'b0;
  localparam logic ACT_PIXEL_FETCH = 1'b1;

  localparam int RowBytesLog2 = 7;
  localparam int CursorWidth  = 15;
  localparam int OffsetWidth  = 15;

  // rgb121 green field to 8 bits: the two bits repeated four times is value * 85
  function automatic byte_t green_expand(input logic [1:0] g);
    green_expand = {g, g, g, g};
  endfunction

endpackage

// File: rtl/vcc_vram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vcc_vram
// Byte video memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vcc_vram
  import vcc_pkg::*;
#(
  parameter int DEPTH = 98304,
  parameter int AW    = 17
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  byte_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output byte_t         rd_data
);

  byte_t mem [DEPTH];
  byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/video_controller_cursor_and_scanout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_controller_cursor_and_scanout
// Bus register writes into four frames of byte video memory, and pixel fetch
// returning rgb121 colour expanded to 8-bit rgb.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with in_action, in_reg_index,
//   in_write_data, in_pixel_row, in_pixel_col. a register write (action 0)
//   gives no result; a pixel fetch (action 1) gives one result on out_red,
//   out_green, out_blue under out_valid / out_stall.
//   throughput: one transaction per cycle of any mix while in_stall is low. a data write goes to
//   the video memory in the cycle it is taken, so a fetch right behind it
//   already sees the new byte.
//   path: a fetch passes the registered memory read, then colour decode into
//   a three-entry result queue, from which its result is offered.
//   stall: while the receiver stalls, the queue fills; in_stall rises once
//   queued plus in-flight results reach three, and drops as results leave.
//   reset: rst_n (synchronous, active low) clears cursor, palette, frame
//   and box registers and empties the queue. the video memory is not
//   cleared; bytes never written read as undefined.
// ----------------------------------------------------------------------------
module video_controller_cursor_and_scanout
  import vcc_pkg::*;
#(
  parameter int FRAME_BYTES = 24576,
  parameter int SCREEN_ROWS = 768,
  parameter int SCREEN_COLS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [3:0] in_reg_index,
  input  logic [7:0] in_write_data,
  input  logic [9:0] in_pixel_row,
  input  logic [7:0] in_pixel_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  localparam int MemDepth = 4 * FRAME_BYTES;
  localparam int MemAw    = $clog2(MemDepth);
  localparam int QDepth   = 3;

  // configuration state
  logic [CursorWidth-1:0] cursor_r, cursor_nxt;
  logic [1:0]             target_frame_r, target_frame_nxt;
  logic [3:0]             two_colour_r, two_colour_nxt;
  colour_t                colour_zero_r, colour_zero_nxt;
  colour_t                colour_one_r, colour_one_nxt;
  logic [1:0]             shown_frame_r [4];
  logic [1:0]             shown_frame_nxt [4];
  logic                   box_off_r, box_off_nxt;
  logic [6:0]             box_width_r, box_width_nxt;
  byte_t                  box_height_r, box_height_nxt;
  byte_t                  box_col_cnt_r, box_col_cnt_nxt;
  byte_t                  box_row_cnt_r, box_row_cnt_nxt;
  byte_t                  box_left_r, box_left_nxt;
  byte_t                  box_top_r, box_top_nxt;
  byte_t                  last_byte_r, last_byte_nxt;

  logic       in_acc;
  logic       reg_acc;
  logic       fetch_acc;
  reg_index_t reg_idx;
  conf_cmd_t  conf_cmd;
  byte_t      store_byte;
  logic       do_store;
  logic       store_in_frame;
  byte_t      box_nx;
  byte_t      box_row_nx;

  logic             wr_en;
  logic [MemAw-1:0] wr_addr;
  logic [MemAw-1:0] rd_addr;
  byte_t            rd_data;

  // fetch address
  logic [1:0]             f_frame;
  logic                   f_two;
  logic [OffsetWidth-1:0] f_off;
  logic                   f_on_screen;
  logic                   f_in_frame;

  // read stage
  logic       s1_v_r;
  logic       s1_zero_r;
  logic       s1_oob_r;
  logic       s1_two_r;
  logic [2:0] s1_sel_r;
  colour_t    s1_c0_r;
  colour_t    s1_c1_r;
  byte_t      s1_byte;
  colour_t    s1_colour;
  logic       s1_bit;

  // result queue
  colour_t    q_r [QDepth];
  logic [1:0] q_wr_ptr_r;
  logic [1:0] q_rd_ptr_r;
  logic [1:0] q_cnt_r;
  logic       q_pop;
  colour_t    q_head;

  assign in_acc    = in_valid && !in_stall;
  assign reg_acc   = in_acc && (in_action == ACT_REG_WRITE);
  assign fetch_acc = in_acc && (in_action == ACT_PIXEL_FETCH);
  assign reg_idx   = reg_index_t'(in_reg_index);
  assign conf_cmd  = conf_cmd_t'(in_write_data[7:4]);

  assign do_store   = reg_acc && ((reg_idx == REG_REPT) || (reg_idx == REG_WDAT));
  assign store_byte = (reg_idx == REG_WDAT) ? in_write_data : last_byte_r;
  assign store_in_frame = 16'(cursor_r) < 16'(FRAME_BYTES);

  assign box_nx     = 8'(cursor_r[RowBytesLog2-1:0]) + 8'd1;
  assign box_row_nx = cursor_r[CursorWidth-1:RowBytesLog2] + 8'd1;

  always_comb begin
    cursor_nxt       = cursor_r;
    target_frame_nxt = target_frame_r;
    two_colour_nxt   = two_colour_r;
    colour_zero_nxt  = colour_zero_r;
    colour_one_nxt   = colour_one_r;
    shown_frame_nxt  = shown_frame_r;
    box_off_nxt      = box_off_r;
    box_width_nxt    = box_width_r;
    box_height_nxt   = box_height_r;
    box_col_cnt_nxt  = box_col_cnt_r;
    box_row_cnt_nxt  = box_row_cnt_r;
    box_left_nxt     = box_left_r;
    box_top_nxt      = box_top_r;
    last_byte_nxt    = last_byte_r;
    if (reg_acc) begin
      unique case (reg_idx)
        REG_CONF: begin
          unique case (conf_cmd)
            CONF_FRAME: target_frame_nxt = in_write_data[1:0];
            CONF_MODE:  two_colour_nxt[target_frame_r] = in_write_data[0];
            CONF_COL0:  colour_zero_nxt = in_write_data[3:0];
            CONF_COL1:  colour_one_nxt = in_write_data[3:0];
            default: ;
          endcase
        end
        REG_PTRX: begin
          box_col_cnt_nxt = '0;
          box_row_cnt_nxt = '0;
          box_left_nxt    = {1'b0, in_write_data[6:0]};
          cursor_nxt      = {cursor_r[CursorWidth-1:RowBytesLog2], in_write_data[6:0]};
        end
        REG_PTRY: begin
          box_top_nxt = in_write_data;
          cursor_nxt  = {in_write_data, cursor_r[RowBytesLog2-1:0]};
        end
        REG_DISP: begin
          shown_frame_nxt[0] = in_write_data[7:6];
          shown_frame_nxt[1] = in_write_data[5:4];
          shown_frame_nxt[2] = in_write_data[3:2];
          shown_frame_nxt[3] = in_write_data[1:0];
        end
        REG_CHRW: begin
          box_off_nxt   = in_write_data[7];
          box_width_nxt = in_write_data[6:0];
        end
        REG_CHRH: box_height_nxt = in_write_data;
        REG_REPT, REG_WDAT: begin
          if (reg_idx == REG_WDAT) begin
            last_byte_nxt = in_write_data;
          end
          if (!box_off_r && (box_col_cnt_r == {1'b0, box_width_r})) begin
            box_col_cnt_nxt = '0;
            if (box_row_cnt_r == box_height_r) begin
              // next box column; a carry out of the column lands in the row low bit
              cursor_nxt      = {box_top_r, 7'd0} | 15'(box_nx);
              box_left_nxt    = box_nx;
              box_row_cnt_nxt = '0;
            end else begin
              cursor_nxt      = {box_row_nx, 7'd0} | 15'(box_left_r);
              box_row_cnt_nxt = box_row_cnt_r + 8'd1;
            end
          end else begin
            cursor_nxt      = cursor_r + 15'd1;
            box_col_cnt_nxt = box_col_cnt_r + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r       <= '0;
      target_frame_r <= '0;
      two_colour_r   <= '0;
      colour_zero_r  <= '0;
      colour_one_r   <= '0;
      shown_frame_r  <= '{default: '0};
      box_off_r      <= 1'b0;
      box_width_r    <= '0;
      box_height_r   <= '0;
      box_col_cnt_r  <= '0;
      box_row_cnt_r  <= '0;
      box_left_r     <= '0;
      box_top_r      <= '0;
      last_byte_r    <= '0;
    end else begin
      cursor_r       <= cursor_nxt;
      target_frame_r <= target_frame_nxt;
      two_colour_r   <= two_colour_nxt;
      colour_zero_r  <= colour_zero_nxt;
      colour_one_r   <= colour_one_nxt;
      shown_frame_r  <= shown_frame_nxt;
      box_off_r      <= box_off_nxt;
      box_width_r    <= box_width_nxt;
      box_height_r   <= box_height_nxt;
      box_col_cnt_r  <= box_col_cnt_nxt;
      box_row_cnt_r  <= box_row_cnt_nxt;
      box_left_r     <= box_left_nxt;
      box_top_r      <= box_top_nxt;
      last_byte_r    <= last_byte_nxt;
    end
  end

  // memory write at the cursor of the target frame
  assign wr_en   = do_store && store_in_frame;
  assign wr_addr = MemAw'(target_frame_r) * MemAw'(FRAME_BYTES) + MemAw'(cursor_r);

  // fetch address decode
  assign f_frame = shown_frame_r[in_pixel_row[1:0]];
  assign f_two   = two_colour_r[f_frame];
  assign f_off   = f_two ? {in_pixel_row[9:2], 2'b00, in_pixel_col[7:3]}
                         : {in_pixel_row[9:2], in_pixel_col[7:1]};
  assign f_on_screen = (11'(in_pixel_row) < 11'(SCREEN_ROWS))
                    && (9'(in_pixel_col) < 9'(SCREEN_COLS));
  assign f_in_frame  = 16'(f_off) < 16'(FRAME_BYTES);
  assign rd_addr     = MemAw'(f_frame) * MemAw'(FRAME_BYTES) + MemAw'(f_off);

  vcc_vram #(
    .DEPTH (MemDepth),
    .AW    (MemAw)
  ) u_vram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (store_byte),
    .rd_en   (fetch_acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // palette and pixel select travel with the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= fetch_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_acc) begin
      s1_zero_r <= !f_on_screen;
      s1_oob_r  <= !f_in_frame;
      s1_two_r  <= f_two;
      s1_sel_r  <= f_two ? in_pixel_col[2:0] : {2'b00, in_pixel_col[0]};
      s1_c0_r   <= colour_zero_r;
      s1_c1_r   <= colour_one_r;
    end
  end

  // a byte beyond the frame reads as zero
  assign s1_byte = s1_oob_r ? 8'h00 : rd_data;
  assign s1_bit  = s1_byte[3'd7 - s1_sel_r];

  always_comb begin
    if (s1_zero_r) begin
      s1_colour = '0;
    end else if (s1_two_r) begin
      s1_colour = s1_bit ? s1_c1_r : s1_c0_r;
    end else begin
      s1_colour = s1_sel_r[0] ? s1_byte[3:0] : s1_byte[7:4];
    end
  end

  // result queue
  assign q_pop  = out_valid && !out_stall;
  assign q_head = q_r[q_rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_ptr_r <= '0;
      q_rd_ptr_r <= '0;
      q_cnt_r    <= '0;
    end else begin
      if (s1_v_r) begin
        q_wr_ptr_r <= (q_wr_ptr_r == 2'(QDepth - 1)) ? 2'd0 : q_wr_ptr_r + 2'd1;
      end
      if (q_pop) begin
        q_rd_ptr_r <= (q_rd_ptr_r == 2'(QDepth - 1)) ? 2'd0 : q_rd_ptr_r + 2'd1;
      end
      q_cnt_r <= q_cnt_r + 2'(s1_v_r) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      q_r[q_wr_ptr_r] <= s1_colour;
    end
  end

  assign in_stall  = (3'(q_cnt_r) + 3'(s1_v_r)) >= 3'(QDepth);
  assign out_valid = q_cnt_r != 2'd0;
  assign out_red   = {8{q_head[3]}};
  assign out_blue  = {8{q_head[2]}};
  assign out_green = green_expand(q_head[1:0]);

`ifndef SYNTHESIS
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (3'(q_cnt_r) + 3'(s1_v_r)) <= 3'(QDepth))
    else $error("result queue and read stage exceed capacity");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_v_r && (q_cnt_r == 2'(QDepth)) && !q_pop))
    else $error("result pushed into a full queue");

  a_fetch_reads: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_acc |=> s1_v_r)
    else $error("accepted fetch did not reach the read stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_action == ACT_REG_WRITE)) |=> !s1_v_r)
    else $error("register write produced a read");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    fetch_acc |-> !wr_en)
    else $error("memory write during a pixel fetch");
`endif

endmodule
